// File: sv/indexed_list_engine_assert.svh
// assertion macros shared by the list engine rtl
// expects signals named clk and rst in the scope of use
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// condition holds at every edge outside reset
`define ILE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ILE_ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ile_pkg.sv
// shared constants for the indexed list engine
// no dependencies
package ile_pkg;

  localparam int DEFAULT_CAPACITY = 64;

  localparam int REQ_W   = 3;
  localparam int POS_W   = 8;
  localparam int VALUE_W = 32;
  localparam int ST_W    = 2;
  localparam int LEN_W   = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_HEAD   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_TAIL   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_BEFORE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DELETE = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_DONE   = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;

endpackage

// File: sv/indexed_list_engine.sv
// indexed list engine: request accepted when start && !busy, one result per request on done
// a refused request or a last-entry delete is answered directly from idle; a read passes
//   through S_READ, an append through S_PUT; an insert or delete shifts entries, one moved per cycle
// busy stays high until the result strobe; a new request is taken in the strobe cycle
// results are strobed for one cycle and cannot be stalled by the receiver
// rst (synchronous) empties the list; stored values are undefined until written
`include "indexed_list_engine_assert.svh"

module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [REQ_W-1:0]          req_type,
  input  logic [POS_W-1:0]          position,
  input  logic signed [VALUE_W-1:0] item_value,
  output logic                      done,
  output logic signed [VALUE_W-1:0] read_value,
  output logic [ST_W-1:0]           status,
  output logic [LEN_W-1:0]          length
);

  // address width of the store, width of the list length, and a compare width
  // that holds both the length and an 8-bit position
  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;  // read data returning from the store
  localparam logic [2:0] S_UP    = 3'd2;  // shift entries up to open a gap
  localparam logic [2:0] S_DOWN  = 3'd3;  // shift entries down to close a gap
  localparam logic [2:0] S_FLUSH = 3'd4;  // last pending move is written
  localparam logic [2:0] S_PUT   = 3'd5;  // new value written into the gap

  logic [2:0]         state, state_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic [AW-1:0]      cur, cur_next;         // read cursor of the shift walk
  logic [AW-1:0]      slot, slot_next;       // insert position
  logic [AW-1:0]      waddr, waddr_next;     // destination of the pending move
  logic               pend, pend_next;       // a moved value waits to be written
  logic               ins, ins_next;         // walk belongs to an insert
  logic [VALUE_W-1:0] val, val_next;
  logic               done_next;
  logic [VALUE_W-1:0] rv_next;
  logic [ST_W-1:0]    st_next;
  logic [LEN_W-1:0]   len_next;
  logic               fin;

  // store port signals
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] mem_rdata;

  // request decode in compare width
  logic [CMPW-1:0] n_ext, pos_ext, pos_p1, slot_sel;
  logic [CW-1:0]   cnt_m1;
  logic            full;

  assign n_ext   = CMPW'(cnt);
  assign pos_ext = CMPW'(position);
  assign pos_p1  = pos_ext + CMPW'(1);
  assign cnt_m1  = cnt - CW'(1);
  assign full    = (cnt == CW'(CAPACITY));

  // where an insert lands: head, tail or the given position
  always_comb begin
    case (req_type)
      REQ_HEAD: slot_sel = '0;
      REQ_TAIL: slot_sel = n_ext;
      default:  slot_sel = pos_ext;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cur_next   = cur;
    slot_next  = slot;
    waddr_next = waddr;
    pend_next  = pend;
    ins_next   = ins;
    val_next   = val;
    done_next  = 1'b0;
    rv_next    = read_value;
    st_next    = status;
    len_next   = length;
    fin        = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = waddr;
    mem_wdata  = mem_rdata;
    mem_raddr  = cur;

    case (state)
      S_IDLE: begin
        // a read fetches its entry in the accept cycle
        mem_raddr = pos_ext[AW-1:0];
        if (start) begin
          rv_next  = '0;
          st_next  = ST_DONE;
          val_next = item_value;
          if (req_type == REQ_READ) begin
            if (pos_ext < n_ext) begin
              state_next = S_READ;
            end else begin
              st_next = ST_BADPOS;
              fin     = 1'b1;
            end
          end else if (req_type inside {REQ_HEAD, REQ_TAIL, REQ_BEFORE}) begin
            if (slot_sel > n_ext) begin
              st_next = ST_BADPOS;
              fin     = 1'b1;
            end else if (full) begin
              st_next = ST_FULL;
              fin     = 1'b1;
            end else begin
              ins_next  = 1'b1;
              slot_next = slot_sel[AW-1:0];
              pend_next = 1'b0;
              if (slot_sel == n_ext) begin
                // append: nothing to move
                state_next = S_PUT;
              end else begin
                cur_next   = cnt_m1[AW-1:0];
                state_next = S_UP;
              end
            end
          end else if (req_type == REQ_DELETE) begin
            if (pos_ext < n_ext) begin
              ins_next  = 1'b0;
              pend_next = 1'b0;
              if (pos_p1 < n_ext) begin
                cur_next   = pos_p1[AW-1:0];
                state_next = S_DOWN;
              end else begin
                // last entry dropped: only the length changes
                cnt_next = cnt_m1;
                fin      = 1'b1;
              end
            end else begin
              st_next = ST_BADPOS;
              fin     = 1'b1;
            end
          end else begin
            // unknown request code
            st_next = ST_BADPOS;
            fin     = 1'b1;
          end
        end
      end

      S_READ: begin
        rv_next = mem_rdata;
        fin     = 1'b1;
      end

      S_UP: begin
        // read cur now, write it one place higher next cycle
        mem_we     = pend;
        pend_next  = 1'b1;
        waddr_next = cur + AW'(1);
        if (cur == slot) begin
          state_next = S_FLUSH;
        end else begin
          cur_next = cur - AW'(1);
        end
      end

      S_DOWN: begin
        // read cur now, write it one place lower next cycle
        mem_we     = pend;
        pend_next  = 1'b1;
        waddr_next = cur - AW'(1);
        if (cur == cnt_m1[AW-1:0]) begin
          state_next = S_FLUSH;
        end else begin
          cur_next = cur + AW'(1);
        end
      end

      S_FLUSH: begin
        mem_we    = 1'b1;
        pend_next = 1'b0;
        if (ins) begin
          state_next = S_PUT;
        end else begin
          cnt_next = cnt_m1;
          fin      = 1'b1;
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = slot;
        mem_wdata = val;
        cnt_next  = cnt + CW'(1);
        fin       = 1'b1;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (fin) begin
      state_next = S_IDLE;
      done_next  = 1'b1;
      len_next   = LEN_W'(cnt_next);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      done  <= done_next;
    end
  end

  // walk registers and result payload
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    slot       <= slot_next;
    waddr      <= waddr_next;
    ins        <= ins_next;
    val        <= val_next;
    read_value <= rv_next;
    status     <= st_next;
    length     <= len_next;
  end

  ile_store #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // list length never passes the capacity
  `ILE_ASSERT_ALWAYS(a_cnt_bound, cnt <= CW'(CAPACITY), "list length above capacity")
  // result strobe comes with the engine ready again
  `ILE_ASSERT_IMPLIES(a_done_idle, done, !busy, "result strobed while busy")
  // a full refusal only happens on a full list
  `ILE_ASSERT_IMPLIES(a_full_status, done && status == ST_FULL, full, "full on non-full list")
  // reported length matches the stored length
  `ILE_ASSERT_IMPLIES(a_len_match, done, length == LEN_W'(cnt), "reported length mismatch")
  // an accepted request either answers at once or keeps the engine busy
  `ILE_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "request accepted and lost")

endmodule

// File: sv/ile_store.sv
// value store of the list engine: one write port, one registered read port
// depends on ile_pkg
module ile_store
  import ile_pkg::*;
#(
  parameter int DEPTH = DEFAULT_CAPACITY,
  parameter int AW    = $clog2(DEFAULT_CAPACITY)
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [VALUE_W-1:0] wdata,
  input  logic [AW-1:0]      raddr,
  output logic [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: tb/tb_indexed_list_engine.sv
// self-checking testbench for indexed_list_engine: directed corner requests, then random
// grow and shrink sweeps under several sender idle rates, checked by a list predictor
// depends on ile_pkg and the indexed_list_engine rtl
module tb_indexed_list_engine;
  import ile_pkg::*;

  localparam int LIST_CAP = DEFAULT_CAPACITY;
  localparam int MAX_GAP  = 40;

  // request codes with no meaning, answered as invalid
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd5;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  localparam logic [POS_W-1:0] POS_MAX      = '1;

  // one expected answer per accepted request
  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic [ST_W-1:0]           status;
    logic [LEN_W-1:0]          length;
  } list_answer_t;

  // list predictor plus queue of answers still owed by the engine
  class list_scoreboard;
    logic signed [VALUE_W-1:0] slots [LIST_CAP];
    int unsigned               fill;
    list_answer_t              owed_q[$];
    int                        errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    // apply one accepted request to the shadow list and queue its answer
    function void note_request(logic [REQ_W-1:0] req, logic [POS_W-1:0] pos,
                               logic signed [VALUE_W-1:0] val);
      list_answer_t ans;
      int unsigned  slot;
      int unsigned  k;
      ans        = '0;
      ans.status = ST_DONE;
      case (req)
        REQ_READ: begin
          if (pos < fill) ans.read_value = slots[pos];
          else ans.status = ST_BADPOS;
        end
        REQ_HEAD, REQ_TAIL, REQ_BEFORE: begin
          // head and tail are inserts before slot 0 and slot fill
          slot = (req == REQ_HEAD) ? 0 : (req == REQ_TAIL) ? fill : pos;
          // a bad position wins over a full list
          if (slot > fill) begin
            ans.status = ST_BADPOS;
          end else if (fill >= LIST_CAP) begin
            ans.status = ST_FULL;
          end else begin
            for (k = fill; k > slot; k--) slots[k] = slots[k-1];
            slots[slot] = val;
            fill++;
          end
        end
        REQ_DELETE: begin
          if (pos < fill) begin
            for (k = pos; k + 1 < fill; k++) slots[k] = slots[k+1];
            fill--;
          end else begin
            ans.status = ST_BADPOS;
          end
        end
        default: ans.status = ST_BADPOS;
      endcase
      ans.length = fill[LEN_W-1:0];
      owed_q.push_back(ans);
    endfunction

    task report(string what, longint got, longint want);
      errors++;
      $display("ERROR at %0t: %s is %0d, should be %0d", $time, what, got, want);
    endtask

    // compare one strobed result with the oldest owed answer
    task check_result(logic signed [VALUE_W-1:0] rd, logic [ST_W-1:0] st,
                      logic [LEN_W-1:0] len);
      list_answer_t want;
      if (owed_q.size() == 0) begin
        report("unrequested result, status", st, 0);
        return;
      end
      want = owed_q.pop_front();
      if (rd !== want.read_value) report("read_value", rd, want.read_value);
      if (st !== want.status) report("status", st, want.status);
      if (len !== want.length) report("length", len, want.length);
    endtask

    function int outstanding();
      return owed_q.size();
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      start = 1'b0;
  logic                      busy;
  logic [REQ_W-1:0]          req_type = REQ_READ;
  logic [POS_W-1:0]          position = '0;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic                      done;
  logic signed [VALUE_W-1:0] read_value;
  logic [ST_W-1:0]           status;
  logic [LEN_W-1:0]          length;

  list_scoreboard sb = new();

  // sender idle percentage of the current phase
  int idle_pct = 0;
  // list length as the driver expects it after every request sent so far
  int unsigned sent_len = 0;
  // random sweep direction: fill the list up, then drain it
  bit growing = 1'b1;

  indexed_list_engine #(.CAPACITY(LIST_CAP)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req_type  (req_type),
    .position  (position),
    .item_value(item_value),
    .done      (done),
    .read_value(read_value),
    .status    (status),
    .length    (length)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // watchdog against a hung handshake
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // monitor: results first, since a new request can be taken in the strobe cycle
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(read_value, status, length);
      if (start && !busy) sb.note_request(req_type, position, item_value);
    end
  end

  // present one request after a random idle gap, return at the edge that takes it
  task send_request(input logic [REQ_W-1:0] req, input logic [POS_W-1:0] pos,
                    input logic signed [VALUE_W-1:0] val);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    req_type   <= req;
    position   <= pos;
    item_value <= val;
    do @(posedge clk); while (busy);
    // keep the driver's view of the length in step, only to aim positions
    case (req)
      REQ_HEAD, REQ_TAIL: if (sent_len < LIST_CAP) sent_len++;
      REQ_BEFORE: if (pos <= sent_len && sent_len < LIST_CAP) sent_len++;
      REQ_DELETE: if (pos < sent_len) sent_len--;
      default: ;
    endcase
  endtask

  // one random request: mostly well-aimed, biased toward the sweep direction
  task random_request();
    int                        roll;
    logic [REQ_W-1:0]          req;
    logic [POS_W-1:0]          pos;
    logic signed [VALUE_W-1:0] val;
    roll = $urandom_range(99);
    // value extremes show up often
    case ($urandom_range(9))
      0: val = 32'sh8000_0000;
      1: val = 32'sh7fff_ffff;
      2: val = '0;
      3: val = '1;
      default: val = VALUE_W'($urandom);
    endcase
    if (roll < 6) begin
      // noise: any code, any position, including spare codes and far positions
      req = REQ_W'($urandom_range(REQ_SPARE_HI));
      pos = POS_W'($urandom_range(POS_MAX));
    end else begin
      if (growing) begin
        req = (roll < 72) ? REQ_HEAD : (roll < 88) ? REQ_READ : REQ_DELETE;
      end else begin
        req = (roll < 72) ? REQ_DELETE : (roll < 88) ? REQ_READ : REQ_HEAD;
      end
      if (req == REQ_HEAD) begin
        case ($urandom_range(2))
          0: req = REQ_HEAD;
          1: req = REQ_TAIL;
          default: req = REQ_BEFORE;
        endcase
        pos = POS_W'($urandom_range(sent_len));
      end else begin
        pos = (sent_len == 0) ? '0 : POS_W'($urandom_range(sent_len - 1));
      end
    end
    send_request(req, pos, val);
    // linger at full so refused inserts pile up, turn around when empty
    if (growing && sent_len == LIST_CAP && $urandom_range(7) == 0) growing = 1'b0;
    if (!growing && sent_len == 0) growing = 1'b1;
  endtask

  int idle_phases [4] = '{0, 72, 35, 0};

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty list corners
    send_request(REQ_READ, 8'd0, 32'sd0);
    send_request(REQ_DELETE, 8'd0, 32'sd0);
    send_request(REQ_BEFORE, 8'd1, 32'sd5);
    // tail insert into an empty list becomes the only entry
    send_request(REQ_TAIL, 8'd0, 32'sh7fff_ffff);
    send_request(REQ_HEAD, POS_MAX, 32'sh8000_0000);
    // insert before position equal to length appends
    send_request(REQ_BEFORE, 8'd2, 32'sd0);
    send_request(REQ_BEFORE, 8'd1, -32'sd1);
    send_request(REQ_READ, 8'd0, 32'sd0);
    send_request(REQ_READ, 8'd3, 32'sd0);
    send_request(REQ_READ, 8'd4, 32'sd0);
    send_request(REQ_READ, POS_MAX, -32'sd1);
    // spare request codes are answered as invalid
    send_request(REQ_SPARE_LO, POS_MAX, -32'sd1);
    send_request(REQ_SPARE_LO + 3'd1, 8'd0, 32'sd1);
    send_request(REQ_SPARE_HI, 8'd1, 32'sh5555_aaaa);
    // far positions for delete and insert-before
    send_request(REQ_DELETE, POS_MAX, 32'sd0);
    send_request(REQ_BEFORE, POS_MAX, 32'sd9);
    send_request(REQ_BEFORE, 8'd5, 32'sd9);
    // delete the last entry, the first, then the last again
    send_request(REQ_DELETE, 8'd3, 32'sd0);
    send_request(REQ_DELETE, 8'd0, 32'sd0);
    send_request(REQ_DELETE, 8'd1, 32'sd0);
    send_request(REQ_READ, 8'd0, 32'sd0);

    // random sweeps, one idle rate per phase
    foreach (idle_phases[p]) begin
      idle_pct = idle_phases[p];
      repeat (150) random_request();
    end
    start <= 1'b0;

    // drain, then leave room for any stray strobe
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (LIST_CAP + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
